// ===== hdl/pmfb_pkg.sv =====
// Shared constants, codes and types of the paged monochrome framebuffer.
package pmfb_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_PAGES   = 8;
    localparam int TILE_BITS   = 8;

    localparam int TILE_DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W     = $clog2(TILE_DEPTH);
    localparam int BIT_W      = $clog2(TILE_BITS);
    localparam int PIDX_W     = $clog2(MAX_PAGES);
    localparam int WORD_W     = TILE_BITS + 1;

    localparam int REQ_W   = 2;
    localparam int COORD_W = 8;
    localparam int COL_W   = 8;
    localparam int PAGE_W  = 4;
    localparam int COUNT_W = 11;

    localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_PAGES   = 1'b1;

    // One memory word: the dirty flag above the tile's pixel bits.
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_word             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic               status;
        logic               pixel;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

// ===== hdl/pmfb_store.sv =====
// Tile and dirty-flag memory with one write port and one registered read port.
module pmfb_store (
    input  logic               i_clk,
    input  pmfb_pkg::t_mem_req i_req,
    output pmfb_pkg::t_word    o_rdata
);

    pmfb_pkg::t_word r_mem [pmfb_pkg::TILE_DEPTH];
    pmfb_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pmfb_ctrl.sv =====
// Request sequencer: address mapping, read-modify-write, clear sweep and result register.
module pmfb_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pmfb_pkg::COL_W-1:0]     i_columns,
    input  logic [pmfb_pkg::PAGE_W-1:0]    i_pages,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [pmfb_pkg::REQ_W-1:0]     i_req_type,
    input  logic [pmfb_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [pmfb_pkg::COORD_W-1:0]   i_pos_y,
    input  logic                           i_pixel_in,
    output pmfb_pkg::t_mem_req             o_mem,
    input  pmfb_pkg::t_word                i_mem_rdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output pmfb_pkg::t_result              o_result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RMW   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    localparam int PFULL_W = pmfb_pkg::COORD_W - pmfb_pkg::BIT_W;
    localparam int PROD_W  = pmfb_pkg::PIDX_W + pmfb_pkg::COL_W;
    localparam int LIM_W   = pmfb_pkg::COL_W + pmfb_pkg::PAGE_W;

    logic [1:0]                        r_state, n_state;
    logic [pmfb_pkg::ADDR_W-1:0]       r_sweep;
    logic [pmfb_pkg::COUNT_W-1:0]      r_limit;
    logic                              r_init;
    logic [pmfb_pkg::COUNT_W-1:0]      r_dirty_total, n_dirty_total;
    logic                              r_m_valid, n_m_valid;
    pmfb_pkg::t_result                 r_out;
    pmfb_pkg::t_result                 r_hold;
    logic [pmfb_pkg::REQ_W-1:0]        r_req;
    logic [pmfb_pkg::ADDR_W-1:0]       r_addr;
    logic [pmfb_pkg::BIT_W-1:0]        r_bit;
    logic                              r_pix;
    logic                              r_oob;

    logic                              s_acc;
    logic [PFULL_W-1:0]                page_full;
    logic                              oob;
    logic [PROD_W-1:0]                 addr_full;
    logic [LIM_W-1:0]                  lim_full;
    logic                              sweep_last;
    logic                              cur;
    logic                              change;
    logic                              inc;
    logic [pmfb_pkg::TILE_BITS-1:0]    new_tile;
    logic                              res_valid;
    pmfb_pkg::t_result                 res;
    logic                              out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Coordinate check and tile index: page * columns + x.
    assign page_full = i_pos_y[pmfb_pkg::COORD_W-1:pmfb_pkg::BIT_W];
    assign oob = (i_pos_x >= i_columns) || (page_full >= PFULL_W'(i_pages));
    assign addr_full = {{pmfb_pkg::COL_W{1'b0}}, page_full[pmfb_pkg::PIDX_W-1:0]}
                       * {{pmfb_pkg::PIDX_W{1'b0}}, i_columns}
                       + PROD_W'(i_pos_x);
    assign lim_full = {{pmfb_pkg::PAGE_W{1'b0}}, i_columns}
                      * {{pmfb_pkg::COL_W{1'b0}}, i_pages};

    assign sweep_last = (r_sweep == pmfb_pkg::ADDR_W'(pmfb_pkg::TILE_DEPTH - 1));

    // Modify step on the word read back for the pending draw or read.
    assign cur    = i_mem_rdata[r_bit];
    assign change = (r_req == pmfb_pkg::REQ_DRAW) && !r_oob && (cur != r_pix);
    assign inc    = change && !i_mem_rdata[pmfb_pkg::TILE_BITS];

    always_comb begin
        new_tile        = i_mem_rdata[pmfb_pkg::TILE_BITS-1:0];
        new_tile[r_bit] = r_pix;
    end

    always_comb begin
        o_mem.re    = s_acc;
        o_mem.raddr = addr_full[pmfb_pkg::ADDR_W-1:0];
        o_mem.we    = 1'b0;
        o_mem.waddr = r_addr;
        o_mem.wdata = {1'b1, new_tile};
        if (r_state == ST_SWEEP) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = r_sweep;
            o_mem.wdata = {({1'b0, r_sweep} < r_limit), {pmfb_pkg::TILE_BITS{1'b0}}};
        end else if (r_state == ST_RMW) begin
            o_mem.we = change;
        end
    end

    assign out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state       = r_state;
        n_dirty_total = r_dirty_total;
        res_valid     = 1'b0;
        res           = r_hold;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (i_req_type == pmfb_pkg::REQ_CLEAR) ? ST_SWEEP : ST_RMW;
                end
            end
            ST_RMW: begin
                res_valid  = 1'b1;
                res.status = ((r_req == pmfb_pkg::REQ_DRAW) || (r_req == pmfb_pkg::REQ_READ))
                             && r_oob;
                res.pixel  = (r_req == pmfb_pkg::REQ_READ) && !r_oob && cur;
                res.count  = inc ? r_dirty_total + 1'b1 : r_dirty_total;
                n_dirty_total = res.count;
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_dirty_total = r_limit;
                    res_valid     = !r_init;
                    res.status    = 1'b0;
                    res.pixel     = 1'b0;
                    res.count     = r_limit;
                    if (r_init) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HOLD: begin
                res_valid = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (res_valid) begin
            n_state = out_free ? ST_IDLE : ST_HOLD;
        end
    end

    assign n_m_valid = (res_valid && out_free) || (r_m_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_sweep       <= '0;
            r_limit       <= '0;
            r_init        <= 1'b1;
            r_dirty_total <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_dirty_total <= n_dirty_total;
            r_m_valid     <= n_m_valid;
            if (r_state == ST_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (s_acc && (i_req_type == pmfb_pkg::REQ_CLEAR)) begin
                r_sweep <= '0;
                r_limit <= lim_full[pmfb_pkg::COUNT_W-1:0];
                r_init  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_req  <= i_req_type;
            r_addr <= addr_full[pmfb_pkg::ADDR_W-1:0];
            r_bit  <= i_pos_y[pmfb_pkg::BIT_W-1:0];
            r_pix  <= i_pixel_in;
            r_oob  <= oob;
        end
        if (res_valid && out_free) begin
            r_out <= res;
        end else if (res_valid) begin
            r_hold <= res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_result   = r_out;

endmodule

// ===== hdl/paged_mono_framebuffer.sv =====
// Top level of the paged monochrome framebuffer: ports, configuration registers, assertions.
//
// Requests arrive on the slave stream: tuser carries the request type (draw, read, clear)
// and tdata the pixel coordinates and the value to draw. Every request returns exactly one
// result transfer on the master stream: tuser carries the bounds status and tdata the pixel
// read and the number of dirty tiles after the request.
// The configuration channel writes the column count (index 0) and the page count (index 1);
// it is always ready and should be used only while no request is in flight.
// A draw or read reads the tile word from the single memory in the cycle of the transfer and
// writes it back in the next, so a new request is accepted only after the previous one
// has finished. A clear sweeps all 1024 memory words, one a cycle.
// After reset the same sweep zeroes the store and its dirty flags; the slave stream stays not
// ready during that sweep while configuration writes are still taken.
// A stalled master side does not block the next request: the finished result waits in the
// output register and one more result can be parked inside, after which intake stops.
module paged_mono_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // [7:0] pos_x, [15:8] pos_y, [16] pixel_in, [23:17] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] req_type
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // [0] pixel_out, [11:1] dirty_count, [15:12] zero
    output logic [0:0]  o_m_tuser   // [0] status
);

    logic [pmfb_pkg::COL_W-1:0]  r_columns;
    logic [pmfb_pkg::PAGE_W-1:0] r_pages;
    logic [pmfb_pkg::COL_W-1:0]  columns;
    logic [pmfb_pkg::PAGE_W-1:0] pages;
    pmfb_pkg::t_mem_req          mem_req;
    pmfb_pkg::t_word             mem_rdata;
    pmfb_pkg::t_result           result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= pmfb_pkg::COL_W'(pmfb_pkg::MAX_COLUMNS);
            r_pages   <= pmfb_pkg::PAGE_W'(pmfb_pkg::MAX_PAGES);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pmfb_pkg::CFG_COLUMNS: r_columns <= i_cfg_data;
                pmfb_pkg::CFG_PAGES:   r_pages   <= i_cfg_data[pmfb_pkg::PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register values above the store's geometry act as the geometry's maximum.
    assign columns = (r_columns > pmfb_pkg::COL_W'(pmfb_pkg::MAX_COLUMNS))
                     ? pmfb_pkg::COL_W'(pmfb_pkg::MAX_COLUMNS) : r_columns;
    assign pages   = (r_pages > pmfb_pkg::PAGE_W'(pmfb_pkg::MAX_PAGES))
                     ? pmfb_pkg::PAGE_W'(pmfb_pkg::MAX_PAGES) : r_pages;

    pmfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_columns   (columns),
        .i_pages     (pages),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_req_type  (i_s_tuser),
        .i_pos_x     (i_s_tdata[7:0]),
        .i_pos_y     (i_s_tdata[15:8]),
        .i_pixel_in  (i_s_tdata[16]),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_result    (result)
    );

    pmfb_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_m_tdata = {4'b0000, result.count, result.pixel};
    assign o_m_tuser = result.status;

    // Only one request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while the previous one is still at work");

    // The dirty count can never exceed the number of tiles.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[11:1] <= pmfb_pkg::TILE_DEPTH))
        else $error("dirty count above the tile count");

    // The clearing sweep after reset holds off the request stream.
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_s_tready)
        else $error("request stream ready before the reset sweep finished");

endmodule
